FILE: rtl/uhp_pkg.sv
package uhp_pkg;

  localparam int MAX_ACCEPT_LEN = 32;
  localparam int RUN_CAP        = 32;
  localparam int IDX_W          = $clog2(MAX_ACCEPT_LEN);
  localparam int CNT_W          = $clog2(MAX_ACCEPT_LEN + 1);
  localparam int POS_W          = 5;
  localparam int LEN_W          = 6;

  localparam logic [1:0] PH_KEY   = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_TRAIL = 2'd3;

  localparam logic [1:0] KIND_NONE       = 2'd0;
  localparam logic [1:0] KIND_UPGRADE    = 2'd1;
  localparam logic [1:0] KIND_CONNECTION = 2'd2;
  localparam logic [1:0] KIND_ACCEPT     = 2'd3;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam int KEY_UP_LEN   = 7;
  localparam int KEY_CONN_LEN = 10;
  localparam int KEY_ACC_LEN  = 20;
  localparam int VAL_WS_LEN   = 9;
  localparam int VAL_UP_LEN   = 7;

  localparam logic [0:KEY_UP_LEN-1][7:0]   KEY_UP   = "Upgrade";
  localparam logic [0:KEY_CONN_LEN-1][7:0] KEY_CONN = "Connection";
  localparam logic [0:KEY_ACC_LEN-1][7:0]  KEY_ACC  = "Sec-WebSocket-Accept";
  localparam logic [0:VAL_WS_LEN-1][7:0]   VAL_WS   = "websocket";
  localparam logic [0:VAL_UP_LEN-1][7:0]   VAL_UP   = "Upgrade";

  typedef struct packed {
    logic [7:0] header_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic             success;
    logic             upgrade_ok;
    logic             connection_ok;
    logic [LEN_W-1:0] accept_length;
    logic             accept_truncated;
    logic [POS_W-1:0] byte_position;
    logic [7:0]       accept_char;
    logic             run_end;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic             start;
    logic             success;
    logic             upgrade_ok;
    logic             connection_ok;
    logic [CNT_W-1:0] count;
    logic             overflow;
    logic             bank;
  } verdict_t;

  function automatic logic is_blank(input logic [7:0] b);
    return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF;
  endfunction

  function automatic logic key_up_hit(input logic [4:0] pos, input logic [7:0] b);
    return (pos < 5'(KEY_UP_LEN)) && (KEY_UP[pos[2:0]] == b);
  endfunction

  function automatic logic key_conn_hit(input logic [4:0] pos, input logic [7:0] b);
    return (pos < 5'(KEY_CONN_LEN)) && (KEY_CONN[pos[3:0]] == b);
  endfunction

  function automatic logic key_acc_hit(input logic [4:0] pos, input logic [7:0] b);
    return (pos < 5'(KEY_ACC_LEN)) && (KEY_ACC[pos] == b);
  endfunction

  function automatic logic val_ws_hit(input logic [3:0] pos, input logic [7:0] b);
    return (pos < 4'(VAL_WS_LEN)) && (VAL_WS[pos] == b);
  endfunction

  function automatic logic val_up_hit(input logic [3:0] pos, input logic [7:0] b);
    return (pos < 4'(VAL_UP_LEN)) && (VAL_UP[pos[2:0]] == b);
  endfunction

  function automatic logic [1:0] kind_from(input logic [4:0] pos, input logic [2:0] flags);
    logic [1:0] k;
    k = KIND_NONE;
    if (flags[0] && pos == 5'(KEY_UP_LEN)) begin
      k = KIND_UPGRADE;
    end else if (flags[1] && pos == 5'(KEY_CONN_LEN)) begin
      k = KIND_CONNECTION;
    end else if (flags[2] && pos == 5'(KEY_ACC_LEN)) begin
      k = KIND_ACCEPT;
    end
    return k;
  endfunction

endpackage

FILE: rtl/uhp_parser.sv
module uhp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  uhp_pkg::in_item_t   item,
  output uhp_pkg::store_wr_t  wr,
  output uhp_pkg::verdict_t   verdict
);

  localparam int CNT_W = uhp_pkg::CNT_W;
  localparam int IDX_W = uhp_pkg::IDX_W;

  logic [1:0]       phase, phase_next;
  logic [4:0]       key_position, key_position_next;
  logic [2:0]       key_match_flags, key_match_flags_next;
  logic [1:0]       key_kind, key_kind_next;
  logic [3:0]       value_position, value_position_next;
  logic [1:0]       value_match_flags, value_match_flags_next;
  logic             upgrade_seen_ok, upgrade_seen_ok_next;
  logic             connection_seen_ok, connection_seen_ok_next;
  logic [CNT_W-1:0] accept_count, accept_count_next;
  logic             accept_overflow, accept_overflow_next;
  logic             bank, bank_next;
  logic             do_key, do_value;
  logic [1:0]       fin_kind;
  logic [7:0]       b;

  assign b = item.header_byte;

  always_comb begin
    phase_next              = phase;
    key_position_next       = key_position;
    key_match_flags_next    = key_match_flags;
    key_kind_next           = key_kind;
    value_position_next     = value_position;
    value_match_flags_next  = value_match_flags;
    upgrade_seen_ok_next    = upgrade_seen_ok;
    connection_seen_ok_next = connection_seen_ok;
    accept_count_next       = accept_count;
    accept_overflow_next    = accept_overflow;
    bank_next               = bank;
    do_key                  = 1'b0;
    do_value                = 1'b0;
    fin_kind                = uhp_pkg::KIND_NONE;
    wr                      = '0;
    wr.bank                 = bank;
    wr.data                 = b;
    verdict                 = '0;
    verdict.bank            = bank;

    if (take) begin
      case (phase)
        uhp_pkg::PH_KEY: begin
          do_key = 1'b1;
        end
        uhp_pkg::PH_SKIP: begin
          if (!uhp_pkg::is_blank(b)) begin
            phase_next = uhp_pkg::PH_VALUE;
            do_value   = 1'b1;
          end
        end
        uhp_pkg::PH_VALUE: begin
          if (uhp_pkg::is_blank(b)) begin
            phase_next = uhp_pkg::PH_TRAIL;
          end else begin
            do_value = 1'b1;
          end
        end
        default: begin
          if (!uhp_pkg::is_blank(b)) begin
            // close the previous pair, then this byte opens a new key
            if (key_kind == uhp_pkg::KIND_UPGRADE) begin
              upgrade_seen_ok_next = value_match_flags[0] &&
                                     value_position == 4'(uhp_pkg::VAL_WS_LEN);
            end else if (key_kind == uhp_pkg::KIND_CONNECTION) begin
              connection_seen_ok_next = value_match_flags[1] &&
                                        value_position == 4'(uhp_pkg::VAL_UP_LEN);
            end
            key_position_next      = '0;
            key_match_flags_next   = '1;
            key_kind_next          = uhp_pkg::KIND_NONE;
            value_position_next    = '0;
            value_match_flags_next = '1;
            phase_next             = uhp_pkg::PH_KEY;
            do_key                 = 1'b1;
          end
        end
      endcase

      if (do_key) begin
        if (b == uhp_pkg::CHAR_COLON) begin
          key_kind_next = uhp_pkg::kind_from(key_position_next, key_match_flags_next);
          if (key_kind_next == uhp_pkg::KIND_ACCEPT) begin
            accept_count_next    = '0;
            accept_overflow_next = 1'b0;
          end
          phase_next = uhp_pkg::PH_SKIP;
        end else begin
          key_match_flags_next[0] = key_match_flags_next[0] &
                                    uhp_pkg::key_up_hit(key_position_next, b);
          key_match_flags_next[1] = key_match_flags_next[1] &
                                    uhp_pkg::key_conn_hit(key_position_next, b);
          key_match_flags_next[2] = key_match_flags_next[2] &
                                    uhp_pkg::key_acc_hit(key_position_next, b);
          if (key_position_next != 5'd31) begin
            key_position_next = key_position_next + 5'd1;
          end
        end
      end

      if (do_value) begin
        value_match_flags_next[0] = value_match_flags_next[0] &
                                    uhp_pkg::val_ws_hit(value_position_next, b);
        value_match_flags_next[1] = value_match_flags_next[1] &
                                    uhp_pkg::val_up_hit(value_position_next, b);
        if (value_position_next != 4'd15) begin
          value_position_next = value_position_next + 4'd1;
        end
        if (key_kind_next == uhp_pkg::KIND_ACCEPT) begin
          if (accept_count_next < CNT_W'(uhp_pkg::MAX_ACCEPT_LEN)) begin
            wr.en             = 1'b1;
            wr.addr           = accept_count_next[IDX_W-1:0];
            accept_count_next = accept_count_next + 1'b1;
          end else begin
            accept_overflow_next = 1'b1;
          end
        end
      end

      if (item.final_byte) begin
        // judge the open pair, hand off the verdict, start a fresh block
        fin_kind = (phase_next == uhp_pkg::PH_KEY) ?
                   uhp_pkg::kind_from(key_position_next, key_match_flags_next) :
                   key_kind_next;
        if (fin_kind == uhp_pkg::KIND_UPGRADE) begin
          upgrade_seen_ok_next = value_match_flags_next[0] &&
                                 value_position_next == 4'(uhp_pkg::VAL_WS_LEN);
        end else if (fin_kind == uhp_pkg::KIND_CONNECTION) begin
          connection_seen_ok_next = value_match_flags_next[1] &&
                                    value_position_next == 4'(uhp_pkg::VAL_UP_LEN);
        end else if (fin_kind == uhp_pkg::KIND_ACCEPT &&
                     phase_next == uhp_pkg::PH_KEY) begin
          accept_count_next    = '0;
          accept_overflow_next = 1'b0;
        end

        verdict.start         = 1'b1;
        verdict.upgrade_ok    = upgrade_seen_ok_next;
        verdict.connection_ok = connection_seen_ok_next;
        verdict.count         = accept_count_next;
        verdict.overflow      = accept_overflow_next;
        verdict.success       = (accept_count_next != '0) && upgrade_seen_ok_next &&
                                connection_seen_ok_next;

        phase_next              = uhp_pkg::PH_KEY;
        key_position_next       = '0;
        key_match_flags_next    = '1;
        key_kind_next           = uhp_pkg::KIND_NONE;
        value_position_next     = '0;
        value_match_flags_next  = '1;
        upgrade_seen_ok_next    = 1'b0;
        connection_seen_ok_next = 1'b0;
        accept_count_next       = '0;
        accept_overflow_next    = 1'b0;
        bank_next               = ~bank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= uhp_pkg::PH_KEY;
      key_position       <= '0;
      key_match_flags    <= '1;
      key_kind           <= uhp_pkg::KIND_NONE;
      value_position     <= '0;
      value_match_flags  <= '1;
      upgrade_seen_ok    <= 1'b0;
      connection_seen_ok <= 1'b0;
      accept_count       <= '0;
      accept_overflow    <= 1'b0;
      bank               <= 1'b0;
    end else begin
      phase              <= phase_next;
      key_position       <= key_position_next;
      key_match_flags    <= key_match_flags_next;
      key_kind           <= key_kind_next;
      value_position     <= value_position_next;
      value_match_flags  <= value_match_flags_next;
      upgrade_seen_ok    <= upgrade_seen_ok_next;
      connection_seen_ok <= connection_seen_ok_next;
      accept_count       <= accept_count_next;
      accept_overflow    <= accept_overflow_next;
      bank               <= bank_next;
    end
  end

endmodule

FILE: rtl/uhp_emitter.sv
module uhp_emitter (
  input  logic                clk,
  input  logic                rst,
  input  uhp_pkg::store_wr_t  wr,
  input  uhp_pkg::verdict_t   verdict,
  output logic                run_free,
  output logic                result_valid,
  input  logic                result_ready,
  output uhp_pkg::out_item_t  result_item
);

  localparam int CNT_W = uhp_pkg::CNT_W;
  localparam int IDX_W = uhp_pkg::IDX_W;
  localparam int POS_W = uhp_pkg::POS_W;
  localparam int LEN_W = uhp_pkg::LEN_W;
  localparam int DEPTH = 2 * uhp_pkg::MAX_ACCEPT_LEN;

  // two banks: the next block fills one while the run drains the other
  logic [7:0] mem [DEPTH];

  logic              run_busy;
  logic [POS_W-1:0]  run_idx;
  logic [POS_W-1:0]  run_last;
  uhp_pkg::verdict_t run_v;
  logic [CNT_W-1:0]  run_n;
  logic [CNT_W-1:0]  run_n_m1;
  logic              load;
  logic              last_load;

  assign run_n     = (verdict.count > CNT_W'(uhp_pkg::RUN_CAP)) ?
                     CNT_W'(uhp_pkg::RUN_CAP) : verdict.count;
  assign run_n_m1  = (run_n == '0) ? '0 : run_n - 1'b1;
  assign load      = run_busy && (!result_valid || result_ready);
  assign last_load = load && (run_idx == run_last);
  assign run_free  = !run_busy || last_load;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.addr}] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_busy     <= 1'b0;
      run_idx      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (verdict.start) begin
        run_busy <= 1'b1;
        run_idx  <= '0;
      end else if (last_load) begin
        run_busy <= 1'b0;
      end else if (load) begin
        run_idx <= run_idx + 1'b1;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.start) begin
      run_v    <= verdict;
      run_last <= run_n_m1[POS_W-1:0];
    end
    if (load) begin
      result_item.success          <= run_v.success;
      result_item.upgrade_ok       <= run_v.upgrade_ok;
      result_item.connection_ok    <= run_v.connection_ok;
      result_item.accept_length    <= LEN_W'(run_v.count);
      result_item.accept_truncated <= run_v.overflow;
      result_item.byte_position    <= run_idx;
      result_item.run_end          <= (run_idx == run_last);
      if (run_v.count == '0) begin
        result_item.accept_char <= 8'h00;
      end else begin
        result_item.accept_char <= mem[{run_v.bank, IDX_W'(run_idx)}];
      end
    end
  end

endmodule

FILE: rtl/upgrade_header_parser_unit.sv
// Checks an upgrade response header block fed one byte per cycle; a byte that
// is not the last one is taken every cycle and gives no result. The last byte
// produces a run of max(1, min(accept length, 32)) results; the run state is
// registered first, then the results are registered out one per cycle as
// result_ready allows; the rate is set by the accept store's single read port.
// The store has two banks, so bytes of the next block stream in while a run
// drains; a last byte is held off only until the previous run has issued its
// final result. No clearing pass is needed after reset.
module upgrade_header_parser_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  uhp_pkg::in_item_t   byte_item,
  output logic                result_valid,
  input  logic                result_ready,
  output uhp_pkg::out_item_t  result_item
);

  uhp_pkg::store_wr_t wr;
  uhp_pkg::verdict_t  verdict;
  logic               run_free;
  logic               take;

  assign byte_ready = !byte_item.final_byte || run_free;
  assign take       = byte_valid && byte_ready;

  uhp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (byte_item),
    .wr      (wr),
    .verdict (verdict)
  );

  uhp_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .verdict      (verdict),
    .run_free     (run_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  a_empty_run : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.accept_length == '0 |->
      result_item.byte_position == '0 && result_item.run_end &&
      result_item.accept_char == 8'h00)
    else $error("empty accept run malformed");

  a_success : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.success |->
      result_item.upgrade_ok && result_item.connection_ok &&
      result_item.accept_length != '0)
    else $error("success without its conditions");

  a_run_step : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result_item.run_end ##1 result_valid |->
      result_item.byte_position == $past(result_item.byte_position) + 1'b1)
    else $error("run position skipped");

  a_final_gate : assert property (@(posedge clk) disable iff (rst)
    verdict.start |-> run_free)
    else $error("last byte taken while the previous run is still issuing");

endmodule
